>>> hw/rtl/teb_pkg.sv
`default_nettype none
package teb_pkg;

   // Field widths.
   localparam int CoordW = 16;
   localparam int DiffW  = CoordW + 1;
   localparam int ProdW  = 2 * DiffW;
   localparam int EdgeW  = ProdW + 1;
   localparam int MagW   = EdgeW - 1;
   localparam int FracW  = 16;
   localparam int WeightW = 32;
   localparam int SumW   = EdgeW + 2;

   // Divider pipeline: one setup stage, one stage per quotient bit, one result stage.
   localparam int DivLatency = WeightW + 2;

   // Configuration register indexes.
   localparam int CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] RegAX = 3'd0;
   localparam logic [CsrIdxW-1:0] RegAY = 3'd1;
   localparam logic [CsrIdxW-1:0] RegBX = 3'd2;
   localparam logic [CsrIdxW-1:0] RegBY = 3'd3;
   localparam logic [CsrIdxW-1:0] RegCX = 3'd4;
   localparam logic [CsrIdxW-1:0] RegCY = 3'd5;

   localparam logic signed [WeightW-1:0] WeightMax = 32'sh7FFF_FFFF;
   localparam logic signed [WeightW-1:0] WeightMin = 32'sh8000_0000;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic                      inside_res;
      logic                      degenerate;
      logic signed [WeightW-1:0] weight_a;
      logic signed [WeightW-1:0] weight_b;
      logic signed [WeightW-1:0] weight_c;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordW-1:0] ax;
      logic signed [CoordW-1:0] ay;
      logic signed [CoordW-1:0] bx;
      logic signed [CoordW-1:0] by;
      logic signed [CoordW-1:0] cx;
      logic signed [CoordW-1:0] cy;
   } vertex_type;

   // One classified point passed from the front to the back.
   typedef struct packed {
      logic                    is_inside;
      logic signed [EdgeW-1:0] ea;
      logic signed [EdgeW-1:0] eb;
      logic signed [EdgeW-1:0] ec;
      logic signed [EdgeW-1:0] area;
   } edge_item_type;

endpackage
`default_nettype wire

>>> hw/rtl/teb_front.sv
`default_nettype none
module teb_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire teb_pkg::req_type       in_point,
   input  wire teb_pkg::vertex_type    vertex,
   output logic                        out_valid,
   output teb_pkg::edge_item_type      out_item
);
   import teb_pkg::*;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [DiffW-1:0] dax_ff, day_ff, dbx_ff, dby_ff, dcx_ff, dcy_ff;
   logic signed [ProdW-1:0] pa0_ff, pa1_ff, pb0_ff, pb1_ff, pc0_ff, pc1_ff;
   logic signed [EdgeW-1:0] ea_ff, eb_ff, ec_ff;
   logic signed [SumW-1:0]  sum_in;
   edge_item_type           item_ff, item_in;
   logic                    neg, pos;

   // Valid shift line through the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: vertex minus point differences.
   always_ff @(posedge clock) begin
      dax_ff <= DiffW'(vertex.ax) - DiffW'(in_point.point_x);
      day_ff <= DiffW'(vertex.ay) - DiffW'(in_point.point_y);
      dbx_ff <= DiffW'(vertex.bx) - DiffW'(in_point.point_x);
      dby_ff <= DiffW'(vertex.by) - DiffW'(in_point.point_y);
      dcx_ff <= DiffW'(vertex.cx) - DiffW'(in_point.point_x);
      dcy_ff <= DiffW'(vertex.cy) - DiffW'(in_point.point_y);
   end

   // Stage 2: the six cross products.
   always_ff @(posedge clock) begin
      pa0_ff <= dcx_ff * dby_ff;
      pa1_ff <= dcy_ff * dbx_ff;
      pb0_ff <= dax_ff * dcy_ff;
      pb1_ff <= day_ff * dcx_ff;
      pc0_ff <= dbx_ff * day_ff;
      pc1_ff <= dby_ff * dax_ff;
   end

   // Stage 3: edge functions.
   always_ff @(posedge clock) begin
      ea_ff <= EdgeW'(pa0_ff) - EdgeW'(pa1_ff);
      eb_ff <= EdgeW'(pb0_ff) - EdgeW'(pb1_ff);
      ec_ff <= EdgeW'(pc0_ff) - EdgeW'(pc1_ff);
   end

   // Stage 4: the doubled area is the sum of the edges; sign test for inside.
   always_comb begin
      sum_in = SumW'(ea_ff) + SumW'(eb_ff) + SumW'(ec_ff);
      neg = ea_ff[EdgeW-1] | eb_ff[EdgeW-1] | ec_ff[EdgeW-1];
      pos = (!ea_ff[EdgeW-1] && ea_ff != '0) || (!eb_ff[EdgeW-1] && eb_ff != '0) ||
            (!ec_ff[EdgeW-1] && ec_ff != '0);
      item_in.is_inside = !(neg && pos);
      item_in.ea        = ea_ff;
      item_in.eb        = eb_ff;
      item_in.ec        = ec_ff;
      item_in.area      = sum_in[EdgeW-1:0];
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = v4_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

>>> hw/rtl/teb_queue.sv
`default_nettype none
module teb_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire teb_pkg::edge_item_type push_item,
   input  wire logic                   pop_ready,
   output logic                        pop_valid,
   output teb_pkg::edge_item_type      pop_item,
   output logic                        full
);
   import teb_pkg::*;

   edge_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/teb_div.sv
`default_nettype none
module teb_div (
   input  wire logic                             clock,
   input  wire logic signed [teb_pkg::EdgeW-1:0] num,
   input  wire logic signed [teb_pkg::EdgeW-1:0] den,
   output logic signed [teb_pkg::WeightW-1:0]    quot
);
   import teb_pkg::*;

   logic [MagW-1:0]    mag_n, mag_d;
   logic [MagW-1:0]    rem_ff [WeightW+1];
   logic [WeightW-1:0] low_ff [WeightW+1];
   logic [WeightW-1:0] q_ff   [WeightW+1];
   logic [MagW-1:0]    d_ff   [WeightW+1];
   logic               neg_ff [WeightW+1];
   logic               ovf_ff [WeightW+1];
   logic [WeightW-1:0] qm;
   logic signed [WeightW-1:0] quot_ff, quot_in;

   // Setup: magnitudes, quotient sign, and a check for a quotient of 2^32 or more.
   always_comb begin
      mag_n = num[EdgeW-1] ? MagW'(-num) : MagW'(num);
      mag_d = den[EdgeW-1] ? MagW'(-den) : MagW'(den);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= MagW'(mag_n[MagW-1:FracW]);
      low_ff[0] <= {mag_n[FracW-1:0], {(WeightW-FracW){1'b0}}};
      q_ff[0]   <= '0;
      d_ff[0]   <= mag_d;
      neg_ff[0] <= num[EdgeW-1] ^ den[EdgeW-1];
      ovf_ff[0] <= MagW'(mag_n[MagW-1:FracW]) >= mag_d;
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 0; k < WeightW; k++) begin : g_stage
      logic [MagW:0] trial;
      logic          fits;
      always_comb begin
         trial = {rem_ff[k], low_ff[k][WeightW-1]};
         fits  = trial >= {1'b0, d_ff[k]};
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? MagW'(trial - {1'b0, d_ff[k]}) : trial[MagW-1:0];
         low_ff[k+1] <= {low_ff[k][WeightW-2:0], 1'b0};
         q_ff[k+1]   <= {q_ff[k][WeightW-2:0], fits};
         d_ff[k+1]   <= d_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   // Apply sign and saturate to the signed 32-bit range.
   always_comb begin
      qm = q_ff[WeightW];
      if (neg_ff[WeightW]) begin
         if (ovf_ff[WeightW] || (qm[WeightW-1] && qm[WeightW-2:0] != '0)) begin
            quot_in = WeightMin;
         end else begin
            quot_in = -$signed(qm);
         end
      end else begin
         if (ovf_ff[WeightW] || qm[WeightW-1]) begin
            quot_in = WeightMax;
         end else begin
            quot_in = $signed(qm);
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> hw/rtl/teb_back.sv
`default_nettype none
module teb_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire teb_pkg::edge_item_type in_item,
   output logic                        in_ready,
   output logic                        out_valid,
   output teb_pkg::rsp_type            out_rsp
);
   import teb_pkg::*;

   logic                      valid_ff  [DivLatency];
   logic                      inside_ff [DivLatency];
   logic                      degen_ff  [DivLatency];
   logic signed [WeightW-1:0] wa, wb, wc;

   // The divider pipeline never stalls.
   assign in_ready = 1'b1;

   teb_div u_div_a (.clock(clock), .num(in_item.ea), .den(in_item.area), .quot(wa));
   teb_div u_div_b (.clock(clock), .num(in_item.eb), .den(in_item.area), .quot(wb));
   teb_div u_div_c (.clock(clock), .num(in_item.ec), .den(in_item.area), .quot(wc));

   // Flags travel alongside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivLatency; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DivLatency; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      inside_ff[0] <= in_item.is_inside;
      degen_ff[0]  <= (in_item.area == '0);
      for (int i = 1; i < DivLatency; i++) begin
         inside_ff[i] <= inside_ff[i-1];
         degen_ff[i]  <= degen_ff[i-1];
      end
   end

   // Zero area forces all weights to zero.
   always_comb begin
      out_valid          = valid_ff[DivLatency-1];
      out_rsp.inside_res = inside_ff[DivLatency-1];
      out_rsp.degenerate = degen_ff[DivLatency-1];
      out_rsp.weight_a   = degen_ff[DivLatency-1] ? '0 : wa;
      out_rsp.weight_b   = degen_ff[DivLatency-1] ? '0 : wb;
      out_rsp.weight_c   = degen_ff[DivLatency-1] ? '0 : wc;
   end

endmodule
`default_nettype wire

>>> hw/rtl/triangle_edge_barycentric.sv
`default_nettype none
// Point-in-triangle test with barycentric weights. Program the three vertices
// through the csr_ port while no points are in flight; csr_ready is always high
// and indexes six and seven are ignored. A point is taken on every cycle with
// start high and busy low, and busy stays low in operation, so one point per
// clock is sustained. Each point gives exactly one result after it is taken
// (edge arithmetic and queueing, then the bit-per-stage divider), shown for one
// cycle with rsp_valid high. The receiver cannot stall the output, so results
// must be taken as they appear.
module triangle_edge_barycentric (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire teb_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   output teb_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [teb_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [teb_pkg::CoordW-1:0]      csr_data
);
   import teb_pkg::*;

   vertex_type    vertex_ff;
   logic          front_valid;
   edge_item_type front_item;
   logic          q_valid, q_ready, q_full;
   edge_item_type q_item;

   assign csr_ready = 1'b1;
   assign busy      = q_full;

   // Vertex configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegAX:   vertex_ff.ax <= csr_data;
            RegAY:   vertex_ff.ay <= csr_data;
            RegBX:   vertex_ff.bx <= csr_data;
            RegBY:   vertex_ff.by <= csr_data;
            RegCX:   vertex_ff.cx <= csr_data;
            RegCY:   vertex_ff.cy <= csr_data;
            default: ;
         endcase
      end
   end

   teb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_point (req_data),
      .vertex   (vertex_ff),
      .out_valid(front_valid),
      .out_item (front_item)
   );

   teb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_item(front_item),
      .pop_ready(q_ready),
      .pop_valid(q_valid),
      .pop_item (q_item),
      .full     (q_full)
   );

   teb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_item  (q_item),
      .in_ready (q_ready),
      .out_valid(rsp_valid),
      .out_rsp  (rsp_data)
   );

endmodule
`default_nettype wire
